[rtl/puct_pkg.sv]
package puct_pkg;

  localparam int MAX_CHILDREN_DEF = 256;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 56;

  localparam int SCALE_W  = 21;
  localparam int BASE_W   = 20;
  localparam int OFFSET_W = 21;
  localparam int RED_W    = 19;
  localparam int CFG_W    = 21;

  localparam int VISIT_W = 20;
  localparam int VSUM_W  = 37;
  localparam int PRIOR_W = 17;
  localparam int BEST_W  = 8;
  localparam int SCORE_W = 41;

  localparam int LOG_IN_W  = 21;
  localparam int LOG_RES_W = 21;

  localparam int DIV_W     = 57;
  localparam int DIVISOR_W = 21;
  localparam int STEP_W    = 6;

  localparam logic [STEP_W-1:0] SUM_DIV_STEPS = 6'd37;
  localparam logic [STEP_W-1:0] U_DIV_STEPS   = 6'd57;

  localparam logic [15:0] LN2_Q16 = 16'd45426;

  localparam logic [SCALE_W-1:0]  SCALE_RST  = 21'd65536;
  localparam logic [BASE_W-1:0]   BASE_RST   = 20'd19652;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 21'd81920;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_EXPLORE_SCALE       = 2'd0,
    REG_EXPLORE_BASE        = 2'd1,
    REG_EXPLORE_OFFSET      = 2'd2,
    REG_UNVISITED_REDUCTION = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

endpackage

[rtl/puct_child_select.sv]
// PUCT child selector. Feed one word per child, tlast on the final child of a
// parent; one result word (best position, best Q+U score) follows each tlast.
// Words are taken one at a time, each running through a sequencer around one
// shared radix-2 divider (one quotient bit per cycle) and one multiplier. A
// child that was visited needs a 37-step value division and a 57-step
// exploration division; an unvisited child only the exploration division. The
// first child of a parent adds the parent terms: two 16-step log2 passes, a
// 25-step square root and, for a visited parent, a 37-step division; an
// unvisited parent needs only the square root.
// A tlast word holds in its last step while an earlier result is still unread.
module puct_child_select #(
  parameter int MAX_CHILDREN = puct_pkg::MAX_CHILDREN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // parent_visits, parent_value_sum, child_visits, child_value_sum, child_prior
  input  logic [puct_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // best_child, best_score
  output logic [puct_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_addr,
  input  logic [puct_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int PosW = (MAX_CHILDREN > 2) ? $clog2(MAX_CHILDREN) : 1;
  localparam logic [PosW-1:0] PosLast = PosW'(MAX_CHILDREN - 1);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_LGA   = 13'b0000000000010,
    S_LGB   = 13'b0000000000100,
    S_LN    = 13'b0000000001000,
    S_COEF  = 13'b0000000010000,
    S_SQRT  = 13'b0000000100000,
    S_PDIV  = 13'b0000001000000,
    S_CQ    = 13'b0000010000000,
    S_CDIV  = 13'b0000100000000,
    S_U1    = 13'b0001000000000,
    S_U2    = 13'b0010000000000,
    S_UDIV  = 13'b0100000000000,
    S_SCORE = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [puct_pkg::SCALE_W-1:0]  scale_r;
  logic [puct_pkg::BASE_W-1:0]   base_r;
  logic [puct_pkg::OFFSET_W-1:0] offset_r;
  logic [puct_pkg::RED_W-1:0]    red_r;
  logic [puct_pkg::BASE_W-1:0]   base_eff;

  // captured word
  logic [puct_pkg::VISIT_W-1:0]  pn_r, pn_nxt;
  logic [puct_pkg::VSUM_W-1:0]   psum_r, psum_nxt;
  logic [puct_pkg::VISIT_W-1:0]  cn_r, cn_nxt;
  logic [puct_pkg::VSUM_W-1:0]   csum_r, csum_nxt;
  logic [puct_pkg::PRIOR_W-1:0]  prior_r, prior_nxt;
  logic                          last_r, last_nxt;

  // run state
  logic [PosW-1:0]                    pos_r, pos_nxt;
  logic [PosW-1:0]                    best_idx_r, best_idx_nxt;
  logic signed [puct_pkg::SCORE_W-1:0] best_r, best_nxt;
  logic [31:0]                        coef_r, coef_nxt;
  logic [23:0]                        sqrt_r, sqrt_nxt;
  logic signed [19:0]                 pmean_r, pmean_nxt;

  // working registers
  logic [puct_pkg::LOG_RES_W-1:0] la_r, la_nxt;
  logic [puct_pkg::LOG_RES_W-1:0] d_r, d_nxt;
  logic [20:0]                    ln_r, ln_nxt;
  logic [48:0]                    sv_r, sv_nxt;
  logic [49:0]                    sr_r, sr_nxt;
  logic [48:0]                    sb_r, sb_nxt;
  logic signed [37:0]             q_r, q_nxt;
  logic [32:0]                    u1_r, u1_nxt;
  logic [42:0]                    u_r, u_nxt;

  // output register
  logic                             ov_r, ov_nxt;
  logic [puct_pkg::BEST_W-1:0]      ob_r, ob_nxt;
  logic [puct_pkg::SCORE_W-1:0]     os_r, os_nxt;

  // shared units
  logic                             lg_start, lg_done;
  logic [puct_pkg::LOG_IN_W-1:0]    lg_val;
  logic [puct_pkg::LOG_RES_W-1:0]   lg_res;
  puct_pkg::div_ctl_t               div_ctl;
  logic [puct_pkg::DIV_W-1:0]       div_dend;
  logic [puct_pkg::DIVISOR_W-1:0]   div_sor;
  logic                             div_busy, div_done;
  logic [puct_pkg::DIV_W-1:0]       div_q;
  logic [32:0]                      mul_a;
  logic [31:0]                      mul_b;
  logic [64:0]                      prod;

  // combinational helpers
  logic                        accept;
  logic [puct_pkg::VISIT_W-1:0] in_pn, in_cn;
  logic [puct_pkg::VSUM_W-1:0]  in_psum, in_csum;
  logic [puct_pkg::PRIOR_W-1:0] in_prior;
  logic [49:0]                 sq_trial;
  logic                        sq_fit;
  logic [49:0]                 sr_step;
  logic [36:0]                 mag;
  logic                        neg;
  logic [36:0]                 qmag;
  logic signed [37:0]          qs;
  logic signed [44:0]          score_w;
  logic signed [puct_pkg::SCORE_W-1:0] score;
  logic                        can_finish;

  assign in_pn    = in_tdata[19:0];
  assign in_psum  = in_tdata[56:20];
  assign in_cn    = in_tdata[76:57];
  assign in_csum  = in_tdata[113:77];
  assign in_prior = in_tdata[130:114];

  assign base_eff  = (base_r == '0) ? puct_pkg::BASE_W'(1) : base_r;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= puct_pkg::SCALE_RST;
      base_r   <= puct_pkg::BASE_RST;
      offset_r <= puct_pkg::OFFSET_RST;
      red_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        puct_pkg::REG_EXPLORE_SCALE:       scale_r  <= cfg_wdata;
        puct_pkg::REG_EXPLORE_BASE:        base_r   <= cfg_wdata[puct_pkg::BASE_W-1:0];
        puct_pkg::REG_EXPLORE_OFFSET:      offset_r <= cfg_wdata;
        puct_pkg::REG_UNVISITED_REDUCTION: red_r    <= cfg_wdata[puct_pkg::RED_W-1:0];
        default: ;
      endcase
    end
  end

  puct_log u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lg_start),
    .val   (lg_val),
    .done  (lg_done),
    .res   (lg_res)
  );

  puct_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dend),
    .divisor  (div_sor),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_LN: begin
        mul_a = 33'(d_r);
        mul_b = 32'(puct_pkg::LN2_Q16);
      end
      S_COEF: begin
        mul_a = 33'(scale_r);
        mul_b = 32'(ln_r) + 32'(offset_r);
      end
      S_U1: begin
        mul_a = 33'(coef_r);
        mul_b = 32'(prior_r);
      end
      S_U2: begin
        mul_a = u1_r;
        mul_b = 32'(sqrt_r);
      end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;

  // square root step
  assign sq_trial = sr_r + 50'(sb_r);
  assign sq_fit   = 50'(sv_r) >= sq_trial;
  assign sr_step  = sq_fit ? (sr_r >> 1) + 50'(sb_r) : sr_r >> 1;

  // signed quotient from divider magnitude
  assign qmag = div_q[36:0];
  assign qs   = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign neg  = (state_r == S_PDIV) ? psum_r[36] : csum_r[36];
  assign mag  = psum_r[36] ? 37'(-psum_r) : psum_r;

  assign score_w = 45'(q_r) + $signed({2'b0, u_r});
  always_comb begin
    if (score_w > 45'(puct_pkg::SCORE_MAX))      score = puct_pkg::SCORE_MAX;
    else if (score_w < 45'(puct_pkg::SCORE_MIN)) score = puct_pkg::SCORE_MIN;
    else                                         score = score_w[puct_pkg::SCORE_W-1:0];
  end
  assign can_finish = !last_r || !ov_r || out_tready;

  always_comb begin
    state_nxt    = state_r;
    pn_nxt       = pn_r;
    psum_nxt     = psum_r;
    cn_nxt       = cn_r;
    csum_nxt     = csum_r;
    prior_nxt    = prior_r;
    last_nxt     = last_r;
    pos_nxt      = pos_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    coef_nxt     = coef_r;
    sqrt_nxt     = sqrt_r;
    pmean_nxt    = pmean_r;
    la_nxt       = la_r;
    d_nxt        = d_r;
    ln_nxt       = ln_r;
    sv_nxt       = sv_r;
    sr_nxt       = sr_r;
    sb_nxt       = sb_r;
    q_nxt        = q_r;
    u1_nxt       = u1_r;
    u_nxt        = u_r;
    ov_nxt       = ov_r && !out_tready;
    ob_nxt       = ob_r;
    os_nxt       = os_r;
    lg_start     = 1'b0;
    lg_val       = 21'(base_eff);
    div_ctl      = '{start: 1'b0, steps: puct_pkg::SUM_DIV_STEPS};
    div_dend     = {mag, 20'b0};
    div_sor      = 21'(pn_r);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pn_nxt    = in_pn;
          psum_nxt  = in_psum;
          cn_nxt    = in_cn;
          csum_nxt  = in_csum;
          prior_nxt = in_prior;
          last_nxt  = in_tlast;
          if (pos_r != '0) begin
            state_nxt = S_CQ;
          end else if (in_pn != '0) begin
            lg_start  = 1'b1;
            lg_val    = 21'(in_pn) + 21'(base_eff) + 21'd1;
            state_nxt = S_LGA;
          end else begin
            coef_nxt  = 32'(scale_r);
            pmean_nxt = '0;
            sv_nxt    = 49'(in_pn + 20'd1) << 28;
            sr_nxt    = '0;
            sb_nxt    = 49'(1) << 48;
            state_nxt = S_SQRT;
          end
        end
      end
      S_LGA: begin
        if (lg_done) begin
          la_nxt    = lg_res;
          lg_start  = 1'b1;
          state_nxt = S_LGB;
        end
      end
      S_LGB: begin
        if (lg_done) begin
          d_nxt     = (la_r > lg_res) ? la_r - lg_res : '0;
          state_nxt = S_LN;
        end
      end
      S_LN: begin
        ln_nxt    = prod[36:16];
        state_nxt = S_COEF;
      end
      S_COEF: begin
        coef_nxt  = (prod[64:48] != '0) ? 32'hFFFF_FFFF : prod[47:16];
        sv_nxt    = (49'(pn_r) + 49'd1) << 28;
        sr_nxt    = '0;
        sb_nxt    = 49'(1) << 48;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (sq_fit) sv_nxt = 49'(50'(sv_r) - sq_trial);
        sr_nxt = sr_step;
        sb_nxt = sb_r >> 2;
        if (sb_r[0]) begin
          sqrt_nxt = (sr_step > 50'hFF_FFFF) ? 24'hFF_FFFF : sr_step[23:0];
          if (pn_r != '0) begin
            div_ctl   = '{start: 1'b1, steps: puct_pkg::SUM_DIV_STEPS};
            state_nxt = S_PDIV;
          end else begin
            state_nxt = S_CQ;
          end
        end
      end
      S_PDIV: begin
        if (div_done) begin
          if (!psum_r[36] && qmag > 37'd524287)      pmean_nxt = 20'sh7FFFF;
          else if (psum_r[36] && qmag > 37'd524288)  pmean_nxt = 20'sh80000;
          else                                       pmean_nxt = qs[19:0];
          state_nxt = S_CQ;
        end
      end
      S_CQ: begin
        if (cn_r != '0) begin
          div_ctl   = '{start: 1'b1, steps: puct_pkg::SUM_DIV_STEPS};
          div_dend  = {(csum_r[36] ? 37'(-csum_r) : csum_r), 20'b0};
          div_sor   = 21'(cn_r);
          state_nxt = S_CDIV;
        end else begin
          q_nxt     = 38'(pmean_r) - $signed({19'b0, red_r});
          state_nxt = S_U1;
        end
      end
      S_CDIV: begin
        if (div_done) begin
          q_nxt     = qs;
          state_nxt = S_U1;
        end
      end
      S_U1: begin
        u1_nxt    = prod[48:16];
        state_nxt = S_U2;
      end
      S_U2: begin
        div_ctl   = '{start: 1'b1, steps: puct_pkg::U_DIV_STEPS};
        div_dend  = prod[56:0];
        div_sor   = 21'(cn_r) + 21'd1;
        state_nxt = S_UDIV;
      end
      S_UDIV: begin
        if (div_done) begin
          u_nxt     = div_q[56:14];
          state_nxt = S_SCORE;
        end
      end
      S_SCORE: begin
        if (can_finish) begin
          if (pos_r == '0 || score > best_r) begin
            best_nxt     = score;
            best_idx_nxt = pos_r;
          end
          if (last_r) begin
            ov_nxt  = 1'b1;
            ob_nxt  = (pos_r == '0 || score > best_r) ? 8'(pos_r) : 8'(best_idx_r);
            os_nxt  = (pos_r == '0 || score > best_r) ? score : best_r;
            pos_nxt = '0;
          end else if (pos_r < PosLast) begin
            pos_nxt = pos_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pos_r      <= '0;
      best_idx_r <= '0;
      best_r     <= '0;
      coef_r     <= '0;
      sqrt_r     <= '0;
      pmean_r    <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pos_r      <= pos_nxt;
      best_idx_r <= best_idx_nxt;
      best_r     <= best_nxt;
      coef_r     <= coef_nxt;
      sqrt_r     <= sqrt_nxt;
      pmean_r    <= pmean_nxt;
      ov_r       <= ov_nxt;
    end
    pn_r    <= pn_nxt;
    psum_r  <= psum_nxt;
    cn_r    <= cn_nxt;
    csum_r  <= csum_nxt;
    prior_r <= prior_nxt;
    last_r  <= last_nxt;
    la_r    <= la_nxt;
    d_r     <= d_nxt;
    ln_r    <= ln_nxt;
    sv_r    <= sv_nxt;
    sr_r    <= sr_nxt;
    sb_r    <= sb_nxt;
    q_r     <= q_nxt;
    u1_r    <= u1_nxt;
    u_r     <= u_nxt;
    ob_r    <= ob_nxt;
    os_r    <= os_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'b0, os_r, ob_r};

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_busy) else $error("divider started while busy");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PosLast) else $error("child position past limit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready) else $error("ready right after accepting a word");

  a_result_from_score: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_SCORE && last_r))
    else $error("result raised outside final scoring step");

endmodule

[rtl/puct_div.sv]
module puct_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  puct_pkg::div_ctl_t                   ctl,
  input  logic [puct_pkg::DIV_W-1:0]           dividend,
  input  logic [puct_pkg::DIVISOR_W-1:0]       divisor,
  output logic                                 busy,
  output logic                                 done,
  output logic [puct_pkg::DIV_W-1:0]           quot
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [puct_pkg::STEP_W-1:0]       cnt_r, cnt_nxt;
  logic [puct_pkg::DIV_W-1:0]        q_r, q_nxt;
  logic [puct_pkg::DIVISOR_W-1:0]    rem_r, rem_nxt;
  logic [puct_pkg::DIVISOR_W-1:0]    d_r, d_nxt;
  logic [puct_pkg::DIVISOR_W:0]      trial;
  logic                              fits;

  assign trial = {rem_r, q_r[puct_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ctl.steps;
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      // one restoring step: shift in the next dividend bit, subtract if it fits
      rem_nxt = fits ? puct_pkg::DIVISOR_W'(trial - {1'b0, d_r})
                     : trial[puct_pkg::DIVISOR_W-1:0];
      q_nxt   = {q_r[puct_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == puct_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

[rtl/puct_log.sv]
module puct_log (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [puct_pkg::LOG_IN_W-1:0]      val,
  output logic                               done,
  output logic [puct_pkg::LOG_RES_W-1:0]     res
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] m_r, m_nxt;
  logic [15:0] frac_r, frac_nxt;
  logic [4:0]  k_r, k_nxt;
  logic [4:0]  lead;
  logic [puct_pkg::LOG_IN_W-1:0] v1;
  logic [63:0] sq;
  logic [32:0] sq_sh;

  assign v1 = (val == '0) ? puct_pkg::LOG_IN_W'(1) : val;

  always_comb begin
    lead = '0;
    for (int i = 0; i < puct_pkg::LOG_IN_W; i++) begin
      if (v1[i]) lead = 5'(i);
    end
  end

  assign sq    = m_r * m_r;
  assign sq_sh = sq[63:31];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    m_nxt    = m_r;
    frac_nxt = frac_r;
    k_nxt    = k_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      k_nxt    = lead;
      m_nxt    = {11'b0, v1} << (5'd31 - lead);
      frac_nxt = '0;
    end else if (busy_r) begin
      // square the mantissa, renormalize, take one fraction bit
      m_nxt    = sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
      frac_nxt = {frac_r[14:0], sq_sh[32]};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    m_r    <= m_nxt;
    frac_r <= frac_nxt;
    k_r    <= k_nxt;
  end

  assign done = done_r;
  assign res  = {k_r, frac_r};

endmodule
